[sv/sv39_page_table_map_and_check_macros.svh]
// Assertion macros shared by the Sv39 page table block.
`ifndef SV39_PAGE_TABLE_MAP_AND_CHECK_MACROS_SVH
`define SV39_PAGE_TABLE_MAP_AND_CHECK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SV39_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SV39_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sv39ptw_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
`default_nettype none

package sv39ptw_pkg;

    localparam int TABLE_PAGES      = 16;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int VPN_W     = $clog2(ENTRIES_PER_PAGE);
    localparam int PAGE_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int MEM_DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_PAGES + 1);
    localparam int LIM_W     = 5;
    localparam int CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;

    localparam int PPN_W    = 44;
    localparam int VA_W     = 64;
    localparam int PA_W     = 56;
    localparam int PERM_W   = 8;
    localparam int ACC_W    = 3;
    localparam int STATUS_W = 3;
    localparam int PTE_W    = 64;
    localparam int VA_BITS  = 39;
    localparam int PG_OFS_W = 12;
    localparam int PTE_PPN_LSB = 10;

    localparam int PTE_V = 0;
    localparam int PTE_R = 1;
    localparam int PTE_W_BIT = 2;
    localparam int PTE_X = 3;

    localparam int ACC_RD = 0;
    localparam int ACC_WR = 1;
    localparam int ACC_EX = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_VA_TOO_BIG  = 3'd1;
    localparam t_status ST_VA_MISALIGN = 3'd2;
    localparam t_status ST_PA_MISALIGN = 3'd3;
    localparam t_status ST_NO_PAGES    = 3'd4;
    localparam t_status ST_MAPPED      = 3'd5;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_CHECK = 1'b1;

    localparam logic CFG_TABLE_BASE = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    localparam logic [PPN_W-1:0] RST_TABLE_BASE = 44'd524288;
    localparam logic [LIM_W-1:0] RST_PAGE_LIMIT = 5'd16;

    typedef struct packed {
        logic load;
        logic clear;
        logic descend;
        logic alloc;
        logic fail;
        logic leaf_write;
        logic leaf_hit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pre_err;
        logic clr_last;
        logic level_zero;
        logic is_check;
        logic ent_v;
        logic child_ok;
        logic can_alloc;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/sv39ptw_ctrl.sv]
// Walk sequencer: clear sweep, request intake, level walk and result hand-off.
`default_nettype none

module sv39ptw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  sv39ptw_pkg::t_dp_stat i_stat,
    output sv39ptw_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_ALLOC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_stall, n_in_stall;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                // read data lands at the end of this cycle
                n_state = i_stat.pre_err ? S_DONE : S_EVAL;
            end
            S_EVAL: begin
                n_state = S_DONE;
                if (!i_stat.level_zero) begin
                    if (i_stat.ent_v) begin
                        if (i_stat.child_ok) begin
                            o_cmd.descend = 1'b1;
                            n_state       = S_RD;
                        end else if (!i_stat.is_check) begin
                            o_cmd.fail = 1'b1;
                        end
                    end else if (!i_stat.is_check) begin
                        if (i_stat.can_alloc) begin
                            n_state = S_ALLOC;
                        end else begin
                            o_cmd.fail = 1'b1;
                        end
                    end
                end else if (i_stat.ent_v) begin
                    o_cmd.leaf_hit = 1'b1;
                end else if (!i_stat.is_check) begin
                    o_cmd.leaf_write = 1'b1;
                end
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_RD;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_in_stall  = (n_state != S_IDLE);
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_stall  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[sv/sv39ptw_dpath.sv]
// Walk datapath: PTE store, page epochs, allocator, config registers, result registers.
`default_nettype none

module sv39ptw_dpath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sv39ptw_pkg::t_dp_cmd                   i_cmd,
    output sv39ptw_pkg::t_dp_stat                  o_stat,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_index,
    input  logic [sv39ptw_pkg::PPN_W-1:0]          i_cfg_data,
    input  logic                                   i_in_cmd,
    input  logic [sv39ptw_pkg::VA_W-1:0]           i_in_vaddr,
    input  logic [sv39ptw_pkg::PA_W-1:0]           i_in_paddr,
    input  logic [sv39ptw_pkg::PERM_W-1:0]         i_in_perm,
    input  logic [sv39ptw_pkg::ACC_W-1:0]          i_in_access,
    output logic [sv39ptw_pkg::STATUS_W-1:0]       o_out_status,
    output logic                                   o_out_granted,
    output logic [sv39ptw_pkg::PPN_W-1:0]          o_out_leaf_ppn
);

    localparam int VPN_W  = sv39ptw_pkg::VPN_W;
    localparam int PAGE_W = sv39ptw_pkg::PAGE_W;
    localparam int ADDR_W = sv39ptw_pkg::ADDR_W;
    localparam int PPN_W  = sv39ptw_pkg::PPN_W;
    localparam int PTE_W  = sv39ptw_pkg::PTE_W;
    localparam int CNT_W  = sv39ptw_pkg::CNT_W;
    localparam int CMP_W  = sv39ptw_pkg::CMP_W;
    localparam int PERM_W = sv39ptw_pkg::PERM_W;
    localparam int VA_HI  = sv39ptw_pkg::VA_BITS;
    localparam int OFS_W  = sv39ptw_pkg::PG_OFS_W;
    localparam int PPN_LO = sv39ptw_pkg::PTE_PPN_LSB;
    localparam int FLAG_W = PPN_LO;

    // store entry: epoch tag on top of the 64-bit PTE
    logic [PTE_W:0] mem [sv39ptw_pkg::MEM_DEPTH];

    // control state
    logic [PPN_W-1:0]                    r_base;
    logic [sv39ptw_pkg::LIM_W-1:0]       r_limit;
    logic [CNT_W-1:0]                    r_next_free;
    logic [sv39ptw_pkg::TABLE_PAGES-1:0] r_epoch;
    logic [ADDR_W-1:0]                   r_clr;

    // request and walk registers
    logic                                r_is_check;
    logic [3*VPN_W-1:0]                  r_vpn;
    logic [PPN_W-1:0]                    r_pa_ppn;
    logic [PERM_W-1:0]                   r_perm;
    logic [sv39ptw_pkg::ACC_W-1:0]       r_acc;
    logic [PAGE_W-1:0]                   r_page;
    logic [1:0]                          r_level;
    sv39ptw_pkg::t_status                r_status;
    logic                                r_granted;
    logic [PPN_W-1:0]                    r_leaf;
    logic [PTE_W-1:0]                    r_rd_data;
    logic                                r_rd_tag;

    sv39ptw_pkg::t_status                r_out_status;
    logic                                r_out_granted;
    logic [PPN_W-1:0]                    r_out_leaf;

    sv39ptw_pkg::t_status                w_pre_status;
    logic [VPN_W-1:0]                    w_vpn;
    logic [PAGE_W+VPN_W-1:0]             w_addr_full;
    logic [ADDR_W-1:0]                   w_rd_addr;
    logic                                w_wr_en;
    logic [ADDR_W-1:0]                   w_wr_addr;
    logic [PTE_W:0]                      w_wr_data;
    logic                                w_tag_ok;
    logic [PTE_W-1:0]                    w_ent;
    logic [PPN_W-1:0]                    w_ent_ppn;
    logic [PPN_W:0]                      w_diff;
    logic                                w_child_ok;
    logic [PAGE_W-1:0]                   w_child;
    logic [PAGE_W-1:0]                   w_np;
    logic [PPN_W-1:0]                    w_alloc_ppn;
    logic                                w_can_alloc;
    logic                                w_grant;
    logic                                w_cur_epoch;

    // map checks in priority order; a check only tests the va range
    always_comb begin
        w_pre_status = sv39ptw_pkg::ST_OK;
        if (i_in_cmd == sv39ptw_pkg::CMD_CHECK) begin
            if (|i_in_vaddr[sv39ptw_pkg::VA_W-1:VA_HI]) begin
                w_pre_status = sv39ptw_pkg::ST_VA_TOO_BIG;
            end
        end else if (|i_in_vaddr[OFS_W-1:0]) begin
            w_pre_status = sv39ptw_pkg::ST_VA_MISALIGN;
        end else if (|i_in_paddr[OFS_W-1:0]) begin
            w_pre_status = sv39ptw_pkg::ST_PA_MISALIGN;
        end else if (|i_in_vaddr[sv39ptw_pkg::VA_W-1:VA_HI]) begin
            w_pre_status = sv39ptw_pkg::ST_VA_TOO_BIG;
        end
    end

    always_comb begin
        case (r_level)
            2'd2:    w_vpn = r_vpn[3*VPN_W-1:2*VPN_W];
            2'd1:    w_vpn = r_vpn[2*VPN_W-1:VPN_W];
            default: w_vpn = r_vpn[VPN_W-1:0];
        endcase
    end

    assign w_addr_full = {r_page, w_vpn};
    assign w_rd_addr   = w_addr_full[ADDR_W-1:0];
    assign w_cur_epoch = r_epoch[r_page];

    // an entry written before its page's last allocation (or never) reads as zero
    assign w_tag_ok  = (r_rd_tag == w_cur_epoch);
    assign w_ent     = w_tag_ok ? r_rd_data : '0;
    assign w_ent_ppn = w_ent[PPN_LO +: PPN_W];
    assign w_diff    = {1'b0, w_ent_ppn} - {1'b0, r_base};
    assign w_child_ok = !w_diff[PPN_W] &&
                        (w_diff[PPN_W-1:0] < PPN_W'(sv39ptw_pkg::TABLE_PAGES));
    assign w_child   = w_diff[PAGE_W-1:0];

    assign w_np        = r_next_free[PAGE_W-1:0];
    assign w_alloc_ppn = r_base + PPN_W'(w_np);
    assign w_can_alloc = (CMP_W'(r_next_free) < CMP_W'(r_limit)) &&
                         (CMP_W'(r_next_free) < CMP_W'(sv39ptw_pkg::TABLE_PAGES));

    assign w_grant = !(r_acc[sv39ptw_pkg::ACC_RD] && !w_ent[sv39ptw_pkg::PTE_R]) &&
                     !(r_acc[sv39ptw_pkg::ACC_WR] && !w_ent[sv39ptw_pkg::PTE_W_BIT]) &&
                     !(r_acc[sv39ptw_pkg::ACC_EX] && !w_ent[sv39ptw_pkg::PTE_X]);

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_rd_addr;
        w_wr_data = '0;
        if (i_cmd.clear) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
        end else if (i_cmd.alloc) begin
            w_wr_en   = 1'b1;
            w_wr_data = {w_cur_epoch, {(PTE_W-PPN_W-FLAG_W){1'b0}}, w_alloc_ppn,
                         FLAG_W'(1)};
        end else if (i_cmd.leaf_write) begin
            w_wr_en   = 1'b1;
            w_wr_data = {w_cur_epoch, {(PTE_W-PPN_W-FLAG_W){1'b0}}, r_pa_ppn,
                         {(FLAG_W-PERM_W){1'b0}}, r_perm[PERM_W-1:1], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        {r_rd_tag, r_rd_data} <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= sv39ptw_pkg::RST_TABLE_BASE;
            r_limit     <= sv39ptw_pkg::RST_PAGE_LIMIT;
            r_next_free <= CNT_W'(1);
            r_epoch     <= '0;
            r_clr       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sv39ptw_pkg::CFG_TABLE_BASE: r_base  <= i_cfg_data;
                    sv39ptw_pkg::CFG_PAGE_LIMIT: r_limit <= i_cfg_data[sv39ptw_pkg::LIM_W-1:0];
                    default: r_base <= r_base;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.alloc) begin
                r_next_free   <= r_next_free + CNT_W'(1);
                r_epoch[w_np] <= !r_epoch[w_np];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_check <= (i_in_cmd == sv39ptw_pkg::CMD_CHECK);
            r_vpn      <= i_in_vaddr[VA_HI-1:OFS_W];
            r_pa_ppn   <= i_in_paddr[sv39ptw_pkg::PA_W-1:OFS_W];
            r_perm     <= i_in_perm;
            r_acc      <= i_in_access;
            r_page     <= '0;
            r_level    <= 2'd2;
            r_status   <= w_pre_status;
            r_granted  <= 1'b0;
            r_leaf     <= '0;
        end
        if (i_cmd.descend) begin
            r_page  <= w_child;
            r_level <= r_level - 2'd1;
        end
        if (i_cmd.alloc) begin
            r_page  <= w_np;
            r_level <= r_level - 2'd1;
        end
        if (i_cmd.fail) begin
            r_status <= sv39ptw_pkg::ST_NO_PAGES;
        end
        if (i_cmd.leaf_write) begin
            r_leaf <= r_pa_ppn;
        end
        if (i_cmd.leaf_hit) begin
            r_leaf <= w_ent_ppn;
            if (r_is_check) begin
                r_granted <= w_grant;
            end else begin
                r_status <= sv39ptw_pkg::ST_MAPPED;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status  <= r_status;
            r_out_granted <= r_granted;
            r_out_leaf    <= r_leaf;
        end
    end

    always_comb begin
        o_stat.pre_err    = (r_status != sv39ptw_pkg::ST_OK);
        o_stat.clr_last   = (r_clr == ADDR_W'(sv39ptw_pkg::MEM_DEPTH - 1));
        o_stat.level_zero = (r_level == 2'd0);
        o_stat.is_check   = r_is_check;
        o_stat.ent_v      = w_ent[sv39ptw_pkg::PTE_V];
        o_stat.child_ok   = w_child_ok;
        o_stat.can_alloc  = w_can_alloc;
    end

    assign o_out_status   = r_out_status;
    assign o_out_granted  = r_out_granted;
    assign o_out_leaf_ppn = r_out_leaf;

endmodule

`default_nettype wire

[sv/sv39_page_table_map_and_check.sv]
// Top level of the Sv39 page table map and check block.
`default_nettype none

// Keeps a three-level Sv39 page table in an on-chip store of 16 pages x 512 entries and
// serves one map or check request at a time. After reset the store is swept to zero,
// during which no request is taken (config writes are). A request passes through an
// intake state, a read and an evaluate state per table level (one store read port with
// registered data), an allocate state for each table page allocated, and a hand-off
// state. Requests refused on address checks skip the level walk, and a check may stop
// early. Pages handed out by the allocator read
// as zero through a per-page epoch bit, so allocation costs no clearing sweep.
module sv39_page_table_map_and_check (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_in_cmd,
    input  logic [sv39ptw_pkg::VA_W-1:0]           i_in_vaddr,
    input  logic [sv39ptw_pkg::PA_W-1:0]           i_in_paddr,
    input  logic [sv39ptw_pkg::PERM_W-1:0]         i_in_perm,
    input  logic [sv39ptw_pkg::ACC_W-1:0]          i_in_access,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [sv39ptw_pkg::STATUS_W-1:0]       o_out_status,
    output logic                                   o_out_granted,
    output logic [sv39ptw_pkg::PPN_W-1:0]          o_out_leaf_ppn,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic                                   i_cfg_index,
    input  logic [sv39ptw_pkg::PPN_W-1:0]          i_cfg_data
);

    `include "sv39_page_table_map_and_check_macros.svh"

    sv39ptw_pkg::t_dp_cmd  w_cmd;
    sv39ptw_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sv39ptw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sv39ptw_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_cmd       (i_in_cmd),
        .i_in_vaddr     (i_in_vaddr),
        .i_in_paddr     (i_in_paddr),
        .i_in_perm      (i_in_perm),
        .i_in_access    (i_in_access),
        .o_out_status   (o_out_status),
        .o_out_granted  (o_out_granted),
        .o_out_leaf_ppn (o_out_leaf_ppn)
    );

    `SV39_ASSERT_IMP(a_alloc_allowed, w_cmd.alloc, $past(w_stat.can_alloc), "allocation past the page limit")
    `SV39_ASSERT_IMP(a_grant_ok, o_out_valid && o_out_granted, o_out_status == sv39ptw_pkg::ST_OK, "grant with error status")
    `SV39_ASSERT_IMP(a_err_no_leaf, o_out_valid && o_out_status != sv39ptw_pkg::ST_OK && o_out_status != sv39ptw_pkg::ST_MAPPED, o_out_leaf_ppn == '0, "leaf ppn on a failed request")
    `SV39_ASSERT_NXT(a_load_walks, w_cmd.load, o_in_stall, "intake open during a walk")

endmodule

`default_nettype wire
